>>> hdl/ptwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptwd_pkg: shared types and constants of the packed text word decoder
// code values, shift alphabets, queue entry layout and the punctuation table
// ----------------------------------------------------------------------------
package ptwd_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned BudgetW = 8;
  localparam int unsigned CharW   = 7;
  localparam int unsigned CodeW   = 5;
  localparam int unsigned NumCodes = 3;
  localparam int unsigned CntW    = 2;

  // default depth of the queue between front and back
  localparam int unsigned QueueDepthDefault = 4;

  // code values
  localparam logic [CodeW-1:0] CodeSpace     = 5'd0;
  localparam logic [CodeW-1:0] CodeUpper     = 5'd4;
  localparam logic [CodeW-1:0] CodePunct     = 5'd5;
  localparam logic [CodeW-1:0] CodeFirstChar = 5'd6;

  // ascii anchors
  localparam logic [CharW-1:0] CharSpace = 7'h20;
  localparam logic [CharW-1:0] LowerBase = 7'h61;
  localparam logic [CharW-1:0] UpperBase = 7'h41;
  localparam logic [CharW-1:0] CharQuery = 7'h3F;

  // final word marker in a packed word
  localparam int unsigned EndBit = 15;

  typedef enum logic [1:0] {
    ShiftLower = 2'd0,
    ShiftUpper = 2'd1,
    ShiftPunct = 2'd2
  } shift_e;

  // one decoded word: characters packed to the front, count and end flag
  typedef struct packed {
    logic [NumCodes-1:0][CharW-1:0] chars;
    logic [CntW-1:0]                cnt;
    logic                           str_end;
  } ptwd_entry_t;

  // punctuation alphabet, indexed by code minus six
  function automatic logic [CharW-1:0] punct_char(input logic [CodeW-1:0] idx);
    logic [CharW-1:0] ch;
    case (idx)
      5'd0:    ch = 7'h20;
      5'd1:    ch = 7'h5E;
      5'd2:    ch = 7'h30;
      5'd3:    ch = 7'h31;
      5'd4:    ch = 7'h32;
      5'd5:    ch = 7'h33;
      5'd6:    ch = 7'h34;
      5'd7:    ch = 7'h35;
      5'd8:    ch = 7'h36;
      5'd9:    ch = 7'h37;
      5'd10:   ch = 7'h38;
      5'd11:   ch = 7'h39;
      5'd12:   ch = 7'h2E;
      5'd13:   ch = 7'h2C;
      5'd14:   ch = 7'h21;
      5'd15:   ch = 7'h3F;
      5'd16:   ch = 7'h5F;
      5'd17:   ch = 7'h23;
      5'd18:   ch = 7'h27;
      5'd19:   ch = 7'h22;
      5'd20:   ch = 7'h2F;
      5'd21:   ch = 7'h5C;
      5'd22:   ch = 7'h2D;
      5'd23:   ch = 7'h3A;
      5'd24:   ch = 7'h28;
      5'd25:   ch = 7'h29;
      default: ch = CharQuery;
    endcase
    return ch;
  endfunction

endpackage

>>> hdl/ptwd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptwd_front: request intake and classification
// keeps the string state, decodes the three codes of a word and writes one
// queue entry per accepted request
// ----------------------------------------------------------------------------
module ptwd_front import ptwd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                q_full_i,
  input  logic [WordW-1:0]    packed_word_i,
  input  logic                first_word_i,
  input  logic [BudgetW-1:0]  word_budget_i,
  output logic                q_wr_o,
  output ptwd_entry_t         q_wdata_o
);

  shift_e             shift_q, shift_d;
  logic [BudgetW-1:0] taken_q, taken_d;
  logic [BudgetW-1:0] budget_q, budget_d;
  logic               active_q, active_d;

  logic               accept;
  shift_e             shift_eff;
  logic [BudgetW-1:0] taken_eff;
  logic [BudgetW-1:0] budget_eff;
  logic               active_eff;
  logic [BudgetW-1:0] taken_inc;

  logic [NumCodes-1:0][CodeW-1:0] codes;
  logic [NumCodes-1:0][CharW-1:0] ch;
  logic [NumCodes-1:0]            emit;
  shift_e                         mode;
  shift_e                         mode_out;
  logic [CodeW-1:0]               idx;

  assign accept = push_i && !q_full_i;
  assign q_wr_o = accept;

  // state as seen by this request, after a possible new string start
  assign shift_eff  = first_word_i ? ShiftLower : shift_q;
  assign taken_eff  = first_word_i ? '0 : taken_q;
  assign budget_eff = first_word_i ? word_budget_i : budget_q;
  assign active_eff = first_word_i || active_q;
  assign taken_inc  = taken_eff + BudgetW'(1);

  // walk the three codes, most significant first
  always_comb begin
    mode = shift_eff;
    for (int k = 0; k < NumCodes; k++) begin
      codes[k] = packed_word_i[WordW-2-k*CodeW -: CodeW];
      idx      = codes[k] - CodeFirstChar;
      ch[k]    = CharSpace;
      emit[k]  = 1'b0;
      if (codes[k] == CodeSpace) begin
        emit[k] = 1'b1;
        mode    = ShiftLower;
      end else if (codes[k] >= CodeFirstChar) begin
        emit[k] = 1'b1;
        unique case (mode)
          ShiftLower: ch[k] = LowerBase + {2'b00, idx};
          ShiftUpper: ch[k] = UpperBase + {2'b00, idx};
          default:    ch[k] = punct_char(idx);
        endcase
        mode = ShiftLower;
      end else if (codes[k] == CodeUpper) begin
        mode = ShiftUpper;
      end else if (codes[k] == CodePunct) begin
        mode = ShiftPunct;
      end
    end
    mode_out = mode;
  end

  // build the entry and the next string state
  always_comb begin
    shift_d  = shift_q;
    taken_d  = taken_q;
    budget_d = budget_q;
    active_d = active_q;
    q_wdata_o.chars   = '0;
    q_wdata_o.cnt     = '0;
    q_wdata_o.str_end = 1'b1;
    if (accept && active_eff) begin
      shift_d  = shift_eff;
      taken_d  = taken_eff;
      budget_d = budget_eff;
      if (taken_eff >= budget_eff) begin
        active_d = 1'b0;
      end else begin
        taken_d  = taken_inc;
        shift_d  = mode_out;
        q_wdata_o.str_end = packed_word_i[EndBit] || (taken_inc >= budget_eff);
        active_d = !q_wdata_o.str_end;
        q_wdata_o.cnt = CntW'({1'b0, emit[0]} + {1'b0, emit[1]} + {1'b0, emit[2]});
        // pack emitted characters to the front
        q_wdata_o.chars[0] = emit[0] ? ch[0] : (emit[1] ? ch[1] : ch[2]);
        q_wdata_o.chars[1] = (emit[0] && emit[1]) ? ch[1] : ch[2];
        q_wdata_o.chars[2] = ch[2];
      end
    end
  end

  // string state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= ShiftLower;
      taken_q  <= '0;
      budget_q <= '0;
      active_q <= 1'b0;
    end else begin
      shift_q  <= shift_d;
      taken_q  <= taken_d;
      budget_q <= budget_d;
      active_q <= active_d;
    end
  end

`ifndef SYNTHESIS
  a_active_below_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (taken_q < budget_q))
    else $error("running string has no words left in its budget");
`endif

endmodule

>>> hdl/ptwd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptwd_queue: decoupling queue between front and back
// small register queue of decoded word entries
// ----------------------------------------------------------------------------
module ptwd_queue import ptwd_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_i,
  input  ptwd_entry_t wdata_i,
  output logic        full_o,
  input  logic        rd_i,
  output ptwd_entry_t rdata_o,
  output logic        empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntQW = $clog2(Depth + 1);

  ptwd_entry_t         entries_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0]    count_q, count_d;
  logic                do_wr, do_rd;

  assign full_o  = (count_q == CntQW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = entries_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CntQW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CntQW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntQW'(Depth))
    else $error("queue fill count above depth");
`endif

endmodule

>>> hdl/ptwd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptwd_back: result sequencer
// steps through the characters of the head entry, one result per cycle,
// while the output register is empty or popped, into an output register
// ----------------------------------------------------------------------------
module ptwd_back import ptwd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  ptwd_entry_t       q_rdata_i,
  output logic              q_rd_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [CharW-1:0]  character_o,
  output logic              char_valid_o,
  output logic              last_of_item_o,
  output logic              string_end_o
);

  logic [CntW-1:0]  idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] char_q, char_d;
  logic             cvalid_q, cvalid_d;
  logic             last_q, last_d;
  logic             end_q, end_d;

  logic             load;
  logic [CntW-1:0]  cnt_eff;
  logic             is_last;
  logic [CharW-1:0] cur_char;

  assign load    = !q_empty_i && (!out_valid_q || pop_i);
  assign cnt_eff = (q_rdata_i.cnt == '0) ? CntW'(1) : q_rdata_i.cnt;
  assign is_last = ((idx_q + CntW'(1)) == cnt_eff);
  assign q_rd_o  = load && is_last;

  // select the current character of the head entry
  always_comb begin
    case (idx_q)
      2'd0:    cur_char = q_rdata_i.chars[0];
      2'd1:    cur_char = q_rdata_i.chars[1];
      default: cur_char = q_rdata_i.chars[2];
    endcase
  end

  // output register next values
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    cvalid_d    = cvalid_q;
    last_d      = last_q;
    end_d       = end_q;
    if (load) begin
      out_valid_d = 1'b1;
      cvalid_d    = (q_rdata_i.cnt != '0);
      char_d      = cvalid_d ? cur_char : '0;
      last_d      = is_last;
      end_d       = is_last && q_rdata_i.str_end;
      idx_d       = is_last ? '0 : idx_q + CntW'(1);
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q   <= char_d;
    cvalid_q <= cvalid_d;
    last_q   <= last_d;
    end_q    <= end_d;
  end

  assign empty_o        = !out_valid_q;
  assign character_o    = char_q;
  assign char_valid_o   = cvalid_q;
  assign last_of_item_o = last_q;
  assign string_end_o   = end_q;

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd3)
    else $error("character index past three");
  a_mid_has_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> (cvalid_q && !end_q))
    else $error("non-final result without a character or with string end");
  a_idx_zero_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty_i |-> (idx_q == '0))
    else $error("partial entry left with queue empty");
`endif

endmodule

>>> hdl/packed_text_word_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_text_word_decoder: top level
// decodes packed 16-bit text words into a stream of ascii characters
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// words     in         push / full        packed_word_i, first_word_i,
//                                         word_budget_i
// chars     out        empty / pop        character_o, char_valid_o,
//                                         last_of_item_o, string_end_o
//
// a word is decoded in the cycle it is taken and lands in the entry queue;
// the back end gives one result per cycle while results are popped, and a word
// gives one to three results (its character count, at least one).
// the first result passes the entry queue and the output register on its way out.
// reset clears string state, queue pointers and the output valid flag and index.
// full rises only when the entry queue (QueueDepth words) is full.
// ----------------------------------------------------------------------------
module packed_text_word_decoder import ptwd_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [WordW-1:0]   packed_word_i,
  input  logic               first_word_i,
  input  logic [BudgetW-1:0] word_budget_i,
  output logic               empty,
  input  logic               pop,
  output logic [CharW-1:0]   character_o,
  output logic               char_valid_o,
  output logic               last_of_item_o,
  output logic               string_end_o
);

  logic        q_wr;
  logic        q_rd;
  logic        q_full;
  logic        q_empty;
  ptwd_entry_t q_wdata;
  ptwd_entry_t q_rdata;

  assign full = q_full;

  // intake and classification
  ptwd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .q_full_i      (q_full),
    .packed_word_i (packed_word_i),
    .first_word_i  (first_word_i),
    .word_budget_i (word_budget_i),
    .q_wr_o        (q_wr),
    .q_wdata_o     (q_wdata)
  );

  // decoupling queue
  ptwd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  // result sequencing
  ptwd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_rdata_i      (q_rdata),
    .q_rd_o         (q_rd),
    .pop_i          (pop),
    .empty_o        (empty),
    .character_o    (character_o),
    .char_valid_o   (char_valid_o),
    .last_of_item_o (last_of_item_o),
    .string_end_o   (string_end_o)
  );

endmodule
